FILE: design/e2q_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler to quaternion core
// Request and response payload structs, CORDIC constants, arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int AngleWidth = 16;
   localparam int QuatWidth  = 16;
   localparam int CordWidth  = 34;   // Q.30 with headroom for CORDIC growth
   localparam int MaxStages  = 24;

   localparam logic signed [CordWidth-1:0] Q30_PI_HALF = 34'sd1686629713;
   localparam logic signed [CordWidth-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [CordWidth-1:0] Q30_GAIN    = 34'sd652032874;
   localparam logic signed [QuatWidth-1:0] Q14_ONE     = 16'sd16384;

   typedef struct packed {
      logic signed [AngleWidth-1:0] roll_angle;
      logic signed [AngleWidth-1:0] pitch_angle;
      logic signed [AngleWidth-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [QuatWidth-1:0] quat_x;
      logic signed [QuatWidth-1:0] quat_y;
      logic signed [QuatWidth-1:0] quat_z;
      logic signed [QuatWidth-1:0] quat_w;
   } rsp_type;

   // one lane of CORDIC state for one angle
   typedef struct packed {
      logic signed [CordWidth-1:0] x;
      logic signed [CordWidth-1:0] y;
      logic signed [CordWidth-1:0] z;
      logic                        neg;
   } cord_type;

   // atan(2^-i) in units of 2^-30 rad, rounded to nearest
   function automatic logic signed [CordWidth-1:0] atan_lut(input logic [4:0] idx);
      logic signed [CordWidth-1:0] r;
      begin
         case (idx)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

FILE: design/e2q_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_cordic_cell: one CORDIC rotation stage for three angle lanes
// Registered micro-rotation by 2^-STAGE, hands its lanes to the next cell.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire e2q_pkg::cord_type   in_lane [3],
   output logic                     out_valid,
   output e2q_pkg::cord_type        out_lane [3]
);
   import e2q_pkg::*;

   logic              valid_ff;
   cord_type          lane_ff [3];
   cord_type          lane_in [3];
   logic signed [CordWidth-1:0] atan_val;

   assign atan_val = atan_lut(5'(STAGE));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_in[k].neg = in_lane[k].neg;
         if (!in_lane[k].z[CordWidth-1]) begin
            lane_in[k].x = in_lane[k].x - (in_lane[k].y >>> STAGE);
            lane_in[k].y = in_lane[k].y + (in_lane[k].x >>> STAGE);
            lane_in[k].z = in_lane[k].z - atan_val;
         end else begin
            lane_in[k].x = in_lane[k].x + (in_lane[k].y >>> STAGE);
            lane_in[k].y = in_lane[k].y - (in_lane[k].x >>> STAGE);
            lane_in[k].z = in_lane[k].z + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule
`default_nettype wire

FILE: design/e2q_combine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_combine: quaternion product stage
// Pair products, then component sums, rounding and saturation to Q1.14.
// ----------------------------------------------------------------------------
module e2q_combine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire e2q_pkg::cord_type   in_lane [3],
   output logic                     out_valid,
   output e2q_pkg::rsp_type         out_rsp
);
   import e2q_pkg::*;

   localparam int PW = 2 * CordWidth;

   logic signed [CordWidth-1:0] sr, cr, sp, cp, sy, cy;
   logic signed [CordWidth-1:0] sr_ff, cr_ff;
   logic signed [CordWidth-1:0] cpcy_ff, spsy_ff, cpsy_ff, spcy_ff;
   logic signed [CordWidth-1:0] cpcy_in, spsy_in, cpsy_in, spcy_in;
   logic signed [PW-1:0]        rnd;
   logic [1:0]                  valid_ff;
   logic signed [PW-1:0]        ax_ff, bx_ff, ay_ff, by_ff, az_ff, bz_ff, aw_ff, bw_ff;
   rsp_type                     rsp_ff, rsp_in;

   function automatic logic signed [CordWidth-1:0] mulq(
      input logic signed [CordWidth-1:0] a, input logic signed [CordWidth-1:0] b);
      logic signed [PW-1:0] p;
      begin
         p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
         return CordWidth'(p >>> 30);
      end
   endfunction

   function automatic logic signed [QuatWidth-1:0] to_q14(input logic signed [PW-1:0] s);
      logic signed [PW-1:0] r;
      begin
         r = (s + (PW'(1) <<< 45)) >>> 46;
         if (r > PW'(Q14_ONE)) r = PW'(Q14_ONE);
         if (r < -PW'(Q14_ONE)) r = -PW'(Q14_ONE);
         return QuatWidth'(r);
      end
   endfunction

   // undo the fold by pi
   assign cr = in_lane[0].neg ? -in_lane[0].x : in_lane[0].x;
   assign sr = in_lane[0].neg ? -in_lane[0].y : in_lane[0].y;
   assign cp = in_lane[1].neg ? -in_lane[1].x : in_lane[1].x;
   assign sp = in_lane[1].neg ? -in_lane[1].y : in_lane[1].y;
   assign cy = in_lane[2].neg ? -in_lane[2].x : in_lane[2].x;
   assign sy = in_lane[2].neg ? -in_lane[2].y : in_lane[2].y;

   assign cpcy_in = mulq(cp, cy);
   assign spsy_in = mulq(sp, sy);
   assign cpsy_in = mulq(cp, sy);
   assign spcy_in = mulq(sp, cy);
   assign rnd     = '0;

   always_comb begin
      rsp_in.quat_x = to_q14(ax_ff - bx_ff + rnd);
      rsp_in.quat_y = to_q14(ay_ff + by_ff);
      rsp_in.quat_z = to_q14(az_ff - bz_ff);
      rsp_in.quat_w = to_q14(aw_ff + bw_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[0], in_valid};
      end
      sr_ff   <= sr;
      cr_ff   <= cr;
      cpcy_ff <= cpcy_in;
      spsy_ff <= spsy_in;
      cpsy_ff <= cpsy_in;
      spcy_ff <= spcy_in;
      ax_ff   <= PW'(sr_ff) * PW'(cpcy_ff);
      bx_ff   <= PW'(cr_ff) * PW'(spsy_ff);
      ay_ff   <= PW'(cr_ff) * PW'(spcy_ff);
      by_ff   <= PW'(sr_ff) * PW'(cpsy_ff);
      az_ff   <= PW'(cr_ff) * PW'(cpsy_ff);
      bz_ff   <= PW'(sr_ff) * PW'(spcy_ff);
      aw_ff   <= PW'(cr_ff) * PW'(cpcy_ff);
      bw_ff   <= PW'(sr_ff) * PW'(spsy_ff);
      rsp_ff  <= rsp_in;
   end

   logic out_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

FILE: design/euler_to_quaternion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_core: ZYX Euler angles to unit quaternion
// Channel   Ports                         Direction
// request   start, busy, req_data         in, takes roll/pitch/yaw
// response  rsp_valid, rsp_data           out, quaternion x/y/z/w, Q1.14
// One request per cycle; busy stays low. A request passes through the
// fold register, TRIG_STAGES CORDIC cells, three product/round registers.
// Synchronous active-high reset empties the pipeline; nothing is stored.
// The response shows for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core #(
   parameter int TRIG_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire e2q_pkg::req_type   req_data,
   output logic                    rsp_valid,
   output e2q_pkg::rsp_type        rsp_data
);
   import e2q_pkg::*;

   logic      fold_valid_ff;
   cord_type  fold_ff [3];
   cord_type  fold_in [3];
   logic signed [AngleWidth-1:0] ang [3];
   logic      chain_valid [TRIG_STAGES+1];
   cord_type  chain_lane [TRIG_STAGES+1][3];

   assign busy   = 1'b0;
   assign ang[0] = req_data.roll_angle;
   assign ang[1] = req_data.pitch_angle;
   assign ang[2] = req_data.yaw_angle;

   // fold half angles beyond +-pi/2 by pi
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [CordWidth-1:0] z;
         z = {{(CordWidth-AngleWidth-16){ang[k][AngleWidth-1]}}, ang[k], 16'd0};
         fold_in[k].x   = Q30_GAIN;
         fold_in[k].y   = '0;
         fold_in[k].neg = 1'b0;
         fold_in[k].z   = z;
         if (z > Q30_PI_HALF) begin
            fold_in[k].z   = z - Q30_PI;
            fold_in[k].neg = 1'b1;
         end else if (z < -Q30_PI_HALF) begin
            fold_in[k].z   = z + Q30_PI;
            fold_in[k].neg = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else begin
         fold_valid_ff <= start && !busy;
      end
      fold_ff <= fold_in;
   end

   assign chain_valid[0] = fold_valid_ff;
   assign chain_lane[0]  = fold_ff;

   for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
      e2q_cordic_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_lane   (chain_lane[g]),
         .out_valid (chain_valid[g+1]),
         .out_lane  (chain_lane[g+1])
      );
   end

   e2q_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[TRIG_STAGES]),
      .in_lane   (chain_lane[TRIG_STAGES]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_x <= Q14_ONE && rsp_data.quat_x >= -Q14_ONE))
      else $error("quat_x out of range");
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_w <= Q14_ONE && rsp_data.quat_w >= -Q14_ONE))
      else $error("quat_w out of range");
   a_fold_follows: assert property (@(posedge clock) disable iff (reset)
      start |=> fold_valid_ff)
      else $error("request lost at fold stage");

endmodule
`default_nettype wire
